@@ hdl/wcb_pkg.sv @@
`default_nettype none
package wcb_pkg;

   localparam int NUM_WINDOWS_DEFAULT = 4096;
   localparam int SUM_W = 40;
   localparam int AVG_W = 48;
   localparam int WS_W = 21;
   localparam logic [WS_W-1:0] BIN_WIDTH_RESET = 21'd10000;
   localparam logic [31:0] REF_LENGTH_RESET = 32'd0;
   localparam logic REG_BIN_WIDTH = 1'b0;
   localparam logic REG_REF_LENGTH = 1'b1;
   localparam logic KIND_ACCUMULATE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_ZERO  = 2'd2
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] position;
      logic [15:0] depth;
      logic [11:0] window_index;
   } req_type;

   typedef struct packed {
      logic [31:0]      window_start;
      logic [31:0]      window_end;
      logic [AVG_W-1:0] average;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_MUL,
      ST_CHECK,
      ST_UPDATE,
      ST_QCHK,
      ST_QDIV
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       div_start;
      logic       div_avg;
      logic       mul_load;
      logic       rd_en;
      logic       upd_wr;
      logic       clr_wr;
      logic       rsp_en;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic div_done;
      logic in_range;
      logic len_zero;
      logic clr_done;
   } sts_type;

endpackage
`default_nettype wire

@@ hdl/wcb_ram.sv @@
`default_nettype none
module wcb_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/wcb_datapath.sv @@
`default_nettype none
module wcb_datapath #(
   parameter int NUM_WINDOWS = wcb_pkg::NUM_WINDOWS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wcb_pkg::cmd_type         cmd,
   output wcb_pkg::sts_type              sts,
   input  wire wcb_pkg::req_type         req_data,
   input  wire logic [wcb_pkg::WS_W-1:0] bin_width,
   input  wire logic [31:0]              ref_length,
   output logic                          rsp_valid,
   output wcb_pkg::rsp_type              rsp_data
);

   localparam int AW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
   localparam int QW = wcb_pkg::AVG_W;
   localparam int SW = wcb_pkg::SUM_W;
   localparam int PW = 32 + wcb_pkg::WS_W;
   localparam logic [5:0] DIV_STEPS = 6'(QW);

   function automatic logic [31:0] sat32(input logic [PW:0] v);
      sat32 = (v > (PW+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   wcb_pkg::req_type        req_ff;
   logic [31:0]             div_rem_ff, div_rem_in;
   logic [QW-1:0]           div_quo_ff, div_quo_in;
   logic [31:0]             div_dvs_ff;
   logic [5:0]              div_cnt_ff;
   logic [32:0]             div_t, div_diff;
   logic                    div_ge;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [31:0]             bin_ff, mul_a;
   logic [wcb_pkg::WS_W-1:0] ws_eff;
   logic [PW:0]             start_sum, end_sum;
   logic [31:0]             len;
   logic                    last;
   logic [AW-1:0]           clr_cnt_ff;
   logic [SW-1:0]           ram_rd_data, ram_wr_data;
   logic [SW:0]             sum_w;
   logic                    rsp_valid_ff;
   wcb_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   assign ws_eff = (bin_width == '0) ? wcb_pkg::WS_W'(1) : bin_width;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // shared radix-2 restoring divider
   assign div_t    = {div_rem_ff, div_quo_ff[QW-1]};
   assign div_diff = div_t - {1'b0, div_dvs_ff};
   assign div_ge   = (div_t >= {1'b0, div_dvs_ff});
   assign div_rem_in = div_ge ? div_diff[31:0] : div_t[31:0];
   assign div_quo_in = {div_quo_ff[QW-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DIV_STEPS;
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_rem_ff <= '0;
         if (cmd.div_avg) begin
            div_quo_ff <= {ram_rd_data, 8'd0};
            div_dvs_ff <= len;
         end else begin
            div_quo_ff <= QW'(req_ff.position);
            div_dvs_ff <= 32'(ws_eff);
         end
      end else if (div_cnt_ff != '0) begin
         div_rem_ff <= div_rem_in;
         div_quo_ff <= div_quo_in;
      end
   end

   assign mul_a   = (req_ff.kind == wcb_pkg::KIND_QUERY) ? 32'(req_ff.window_index)
                                                         : div_quo_ff[31:0];
   assign prod_in = PW'(mul_a) * PW'(ws_eff);

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
         bin_ff  <= mul_a;
      end
   end

   assign start_sum = (PW+1)'(prod_ff) + (PW+1)'(1);
   assign end_sum   = (PW+1)'(prod_ff) + (PW+1)'(ws_eff);
   assign last      = end_sum > (PW+1)'(ref_length);
   assign len       = last ? (ref_length - prod_ff[31:0]) : 32'(ws_eff);

   assign sts.is_query = (req_ff.kind == wcb_pkg::KIND_QUERY);
   assign sts.div_done = (div_cnt_ff == '0);
   assign sts.in_range = ({1'b0, bin_ff} < 33'(NUM_WINDOWS)) && (prod_ff <= PW'(ref_length));
   assign sts.len_zero = (len == '0);
   assign sts.clr_done = (clr_cnt_ff == AW'(NUM_WINDOWS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign sum_w       = (SW+1)'(ram_rd_data) + (SW+1)'(req_ff.depth);
   assign ram_wr_data = cmd.clr_wr ? '0 : (sum_w[SW] ? '1 : sum_w[SW-1:0]);

   wcb_ram #(
      .WIDTH (SW),
      .DEPTH (NUM_WINDOWS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_wr | cmd.upd_wr),
      .wr_addr (cmd.clr_wr ? clr_cnt_ff : bin_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (bin_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.status = cmd.rsp_status;
      case (cmd.rsp_status)
         wcb_pkg::STATUS_OK: begin
            rsp_data_in.window_start = sat32(start_sum);
            rsp_data_in.window_end   = sat32(end_sum);
            rsp_data_in.average      = div_quo_ff;
         end
         wcb_pkg::STATUS_ZERO: begin
            rsp_data_in.window_start = sat32(start_sum);
            rsp_data_in.window_end   = sat32(end_sum);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ hdl/wcb_ctrl.sv @@
`default_nettype none
module wcb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wcb_pkg::sts_type sts,
   output wcb_pkg::cmd_type      cmd
);

   wcb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wcb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_status = wcb_pkg::STATUS_OK;
      unique case (state_ff)
         wcb_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_done) begin
               state_in = wcb_pkg::ST_IDLE;
            end
         end
         wcb_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in = wcb_pkg::ST_DISPATCH;
            end
         end
         wcb_pkg::ST_DISPATCH: begin
            if (sts.is_query) begin
               state_in = wcb_pkg::ST_MUL;
            end else begin
               cmd.div_start = 1'b1;
               state_in = wcb_pkg::ST_DIV;
            end
         end
         wcb_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = wcb_pkg::ST_MUL;
            end
         end
         wcb_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in = wcb_pkg::ST_CHECK;
         end
         wcb_pkg::ST_CHECK: begin
            cmd.rd_en = 1'b1;
            if (!sts.in_range) begin
               cmd.rsp_en = 1'b1;
               cmd.rsp_status = wcb_pkg::STATUS_RANGE;
               state_in = wcb_pkg::ST_IDLE;
            end else if (sts.is_query) begin
               state_in = wcb_pkg::ST_QCHK;
            end else begin
               state_in = wcb_pkg::ST_UPDATE;
            end
         end
         wcb_pkg::ST_UPDATE: begin
            cmd.upd_wr = 1'b1;
            state_in = wcb_pkg::ST_IDLE;
         end
         wcb_pkg::ST_QCHK: begin
            if (sts.len_zero) begin
               cmd.rsp_en = 1'b1;
               cmd.rsp_status = wcb_pkg::STATUS_ZERO;
               state_in = wcb_pkg::ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_avg = 1'b1;
               state_in = wcb_pkg::ST_QDIV;
            end
         end
         wcb_pkg::ST_QDIV: begin
            if (sts.div_done) begin
               cmd.rsp_en = 1'b1;
               cmd.rsp_status = wcb_pkg::STATUS_OK;
               state_in = wcb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wcb_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != wcb_pkg::ST_IDLE);

endmodule
`default_nettype wire

@@ hdl/windowed_coverage_binning.sv @@
// Coverage binning: accumulate requests add depth into window position/bin width,
// query requests return one window's start, end and 8-fraction-bit average. After reset
// the bin memory is cleared with busy high. A request is taken when start is high and
// busy low; accumulates and queries share the 48-step radix-2 divider. A result
// shows for one cycle on rsp_valid and cannot be stalled; accumulates that hit a valid
// window give no result.
`default_nettype none
module windowed_coverage_binning #(
   parameter int NUM_WINDOWS = wcb_pkg::NUM_WINDOWS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wcb_pkg::req_type req_data,
   output logic                  rsp_valid,
   output wcb_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [wcb_pkg::WS_W-1:0] bin_width_ff;
   logic [31:0]              ref_length_ff;
   wcb_pkg::cmd_type         cmd;
   wcb_pkg::sts_type         sts;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff  <= wcb_pkg::BIN_WIDTH_RESET;
         ref_length_ff <= wcb_pkg::REF_LENGTH_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == wcb_pkg::REG_BIN_WIDTH) begin
            bin_width_ff <= pwdata[wcb_pkg::WS_W-1:0];
         end else begin
            ref_length_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[2] == wcb_pkg::REG_REF_LENGTH) ? ref_length_ff
                                                         : 32'(bin_width_ff);

   wcb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   wcb_datapath #(
      .NUM_WINDOWS (NUM_WINDOWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .bin_width   (bin_width_ff),
      .ref_length  (ref_length_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");
`endif

endmodule
`default_nettype wire
